FILE: hdl/csq_pkg.sv
// csq_pkg: field widths, request modes and result outcome codes of the semaphore bank
// shared by the channel interfaces and the top level; no dependencies

package csq_pkg;

   // payload field widths
   localparam int MODE_W    = 1;
   localparam int RES_W     = 3;
   localparam int PID_W     = 16;
   localparam int OUTCOME_W = 2;
   localparam int CFG_W     = 4;

   // request modes
   localparam logic [MODE_W-1:0] MODE_WAIT   = 1'b0;
   localparam logic [MODE_W-1:0] MODE_SIGNAL = 1'b1;

   // result outcomes
   localparam logic [OUTCOME_W-1:0] OUT_READY   = 2'd0;
   localparam logic [OUTCOME_W-1:0] OUT_BLOCKED = 2'd1;
   localparam logic [OUTCOME_W-1:0] OUT_EXIT    = 2'd2;
   localparam logic [OUTCOME_W-1:0] OUT_REJECT  = 2'd3;

   // resources_in_use after reset
   localparam logic [CFG_W-1:0] RES_IN_USE_RESET = 4'd8;

endpackage

FILE: hdl/csq_if.sv
// csq channel interfaces: request, result and register write channels, valid/ready handshake
// depends on csq_pkg for the payload widths

interface csq_req_if;
   logic                          valid;
   logic                          ready;
   logic [csq_pkg::MODE_W-1:0]    mode;
   logic [csq_pkg::RES_W-1:0]     resource;
   logic [csq_pkg::PID_W-1:0]     pid;

   modport source (output valid, mode, resource, pid, input ready);
   modport sink   (input valid, mode, resource, pid, output ready);
endinterface

interface csq_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [csq_pkg::PID_W-1:0]     out_pid;
   logic [csq_pkg::OUTCOME_W-1:0] outcome;
   logic                          advance_pc;
   logic                          last;

   modport source (output valid, out_pid, outcome, advance_pc, last, input ready);
   modport sink   (input valid, out_pid, outcome, advance_pc, last, output ready);
endinterface

interface csq_csr_if;
   logic                          valid;
   logic                          ready;
   logic [csq_pkg::CFG_W-1:0]     data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

FILE: hdl/counting_semaphore_wait_queue.sv
// Counting semaphore bank with one FIFO wait queue per resource. A request is taken in S_IDLE;
// the per-resource record (count, queue head, tail, fill) lives in a state memory with a
// registered read, so S_LOOK reads it, decides and writes it back. A signal that releases a
// waiter also reads the waiter store (S_POP) and then hands out two results, the waiter's and
// then the signaller's. A full result register holds the sequencer until the sink takes the
// waiting transaction. Counts, heads, tails and fills read as zero after reset; no clearing
// pass is needed. resources_in_use is written on the csr channel and takes effect for the
// next request.
// depends on csq_pkg, csq_if (csq_req_if, csq_rsp_if, csq_csr_if) and csq_ram

module counting_semaphore_wait_queue #(
   parameter int NUM_RESOURCES = 8,
   parameter int QUEUE_DEPTH   = 16,
   parameter int COUNT_MAX     = 255
) (
   input  logic       clock,
   input  logic       reset,
   csq_req_if.sink    req_ch,
   csq_rsp_if.source  rsp_ch,
   csq_csr_if.sink    csr_ch
);

   // derived widths
   localparam int RIDX_W  = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1;
   localparam int PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int FILL_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int CNT_W   = $clog2(COUNT_MAX + 1);
   localparam int REC_W   = CNT_W + 2 * PTR_W + FILL_W;
   localparam int WDEPTH  = NUM_RESOURCES * QUEUE_DEPTH;
   localparam int WADDR_W = $clog2(WDEPTH);

   // sequencer states
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_LOOK = 3'd1;
   localparam logic [2:0] S_OUT  = 3'd2;
   localparam logic [2:0] S_POP  = 3'd3;
   localparam logic [2:0] S_LAST = 3'd4;

   logic [2:0]                     state_ff, state_in;
   logic [csq_pkg::CFG_W-1:0]      in_use_ff;
   logic [csq_pkg::MODE_W-1:0]     mode_ff;
   logic [RIDX_W-1:0]              ridx_ff;
   logic [csq_pkg::PID_W-1:0]      pid_ff;
   logic                           unknown_ff;
   logic [NUM_RESOURCES-1:0]       rec_valid_ff;
   logic [csq_pkg::OUTCOME_W-1:0]  pend_outcome_ff, pend_outcome_in;
   logic                           pend_adv_ff, pend_adv_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [csq_pkg::PID_W-1:0]      rsp_pid_ff, rsp_pid_in;
   logic [csq_pkg::OUTCOME_W-1:0]  rsp_outcome_ff, rsp_outcome_in;
   logic                           rsp_adv_ff, rsp_adv_in;
   logic                           rsp_last_ff, rsp_last_in;

   logic                           req_take;
   logic                           req_unknown;
   logic [RIDX_W-1:0]              req_ridx;
   logic                           out_free;

   logic [REC_W-1:0]               rec_q;
   logic [REC_W-1:0]               rec_cur;
   logic [REC_W-1:0]               rec_new;
   logic                           rec_we;
   logic [CNT_W-1:0]               cnt, cnt_new;
   logic [PTR_W-1:0]               head, head_new, tail, tail_new;
   logic [FILL_W-1:0]              fill, fill_new;

   logic                           wq_we, wq_re;
   logic [WADDR_W-1:0]             wq_waddr, wq_raddr, wq_base;
   logic [csq_pkg::PID_W-1:0]      wq_q;

   logic                           look_pop;
   logic [csq_pkg::OUTCOME_W-1:0]  look_outcome;
   logic                           look_adv;

   // handshakes
   assign csr_ch.ready = 1'b1;
   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_take     = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign req_ridx     = RIDX_W'(req_ch.resource);
   assign req_unknown  = (csq_pkg::CFG_W'(req_ch.resource) >= in_use_ff) ||
                         (int'(req_ch.resource) >= NUM_RESOURCES);

   // per-resource record memory
   csq_ram #(
      .WIDTH (REC_W),
      .DEPTH (NUM_RESOURCES)
   ) u_rec_ram (
      .clock   (clock),
      .wr_en   (rec_we),
      .wr_addr (ridx_ff),
      .wr_data (rec_new),
      .rd_en   (req_take),
      .rd_addr (req_ridx),
      .rd_data (rec_q)
   );

   // waiter store, QUEUE_DEPTH slots per resource
   csq_ram #(
      .WIDTH (csq_pkg::PID_W),
      .DEPTH (WDEPTH)
   ) u_wait_ram (
      .clock   (clock),
      .wr_en   (wq_we),
      .wr_addr (wq_waddr),
      .wr_data (pid_ff),
      .rd_en   (wq_re),
      .rd_addr (wq_raddr),
      .rd_data (wq_q)
   );

   // record fields, never-written entries read as zero
   assign rec_cur = rec_valid_ff[ridx_ff] ? rec_q : '0;
   assign {cnt, head, tail, fill} = rec_cur;
   assign rec_new = {cnt_new, head_new, tail_new, fill_new};
   assign wq_base = WADDR_W'(ridx_ff) * WADDR_W'(QUEUE_DEPTH);
   assign wq_waddr = wq_base + WADDR_W'(tail);
   assign wq_raddr = wq_base + WADDR_W'(head);

   // decide and update the record of the named resource
   always_comb begin
      cnt_new      = cnt;
      head_new     = head;
      tail_new     = tail;
      fill_new     = fill;
      rec_we       = 1'b0;
      wq_we        = 1'b0;
      wq_re        = 1'b0;
      look_pop     = 1'b0;
      look_outcome = csq_pkg::OUT_READY;
      look_adv     = 1'b0;
      if (state_ff == S_LOOK) begin
         priority if (unknown_ff) begin
            look_outcome = csq_pkg::OUT_EXIT;
         end else if (mode_ff == csq_pkg::MODE_WAIT) begin
            priority if (cnt != '0) begin
               cnt_new  = cnt - CNT_W'(1);
               rec_we   = 1'b1;
               look_adv = 1'b1;
            end else if (fill == FILL_W'(QUEUE_DEPTH)) begin
               look_outcome = csq_pkg::OUT_REJECT;
            end else begin
               wq_we        = 1'b1;
               tail_new     = (tail == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail + PTR_W'(1);
               fill_new     = fill + FILL_W'(1);
               rec_we       = 1'b1;
               look_outcome = csq_pkg::OUT_BLOCKED;
            end
         end else begin
            priority if (fill != '0) begin
               wq_re    = 1'b1;
               head_new = (head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head + PTR_W'(1);
               fill_new = fill - FILL_W'(1);
               rec_we   = 1'b1;
               look_pop = 1'b1;
            end else begin
               if (cnt < CNT_W'(COUNT_MAX)) begin
                  cnt_new = cnt + CNT_W'(1);
               end
               rec_we = 1'b1;
            end
         end
      end
   end

   // sequencer and result register loading
   always_comb begin
      state_in        = state_ff;
      pend_outcome_in = pend_outcome_ff;
      pend_adv_in     = pend_adv_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ch.ready;
      rsp_pid_in      = rsp_pid_ff;
      rsp_outcome_in  = rsp_outcome_ff;
      rsp_adv_in      = rsp_adv_ff;
      rsp_last_in     = rsp_last_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               state_in = S_LOOK;
            end
         end
         S_LOOK: begin
            pend_outcome_in = look_outcome;
            pend_adv_in     = look_adv;
            priority if (look_pop) begin
               state_in = S_POP;
            end else if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_pid_in     = pid_ff;
               rsp_outcome_in = look_outcome;
               rsp_adv_in     = look_adv;
               rsp_last_in    = 1'b1;
               state_in       = S_IDLE;
            end else begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_pid_in     = pid_ff;
               rsp_outcome_in = pend_outcome_ff;
               rsp_adv_in     = pend_adv_ff;
               rsp_last_in    = 1'b1;
               state_in       = S_IDLE;
            end
         end
         S_POP: begin
            // oldest waiter first, pc advanced
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_pid_in     = wq_q;
               rsp_outcome_in = csq_pkg::OUT_READY;
               rsp_adv_in     = 1'b1;
               rsp_last_in    = 1'b0;
               state_in       = S_LAST;
            end
         end
         S_LAST: begin
            // then the signaller, no advance
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_pid_in     = pid_ff;
               rsp_outcome_in = csq_pkg::OUT_READY;
               rsp_adv_in     = 1'b0;
               rsp_last_in    = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         in_use_ff    <= csq_pkg::RES_IN_USE_RESET;
         rec_valid_ff <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_ch.valid && csr_ch.ready) begin
            in_use_ff <= csr_ch.data;
         end
         if (rec_we) begin
            rec_valid_ff[ridx_ff] <= 1'b1;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         mode_ff    <= req_ch.mode;
         ridx_ff    <= req_ridx;
         pid_ff     <= req_ch.pid;
         unknown_ff <= req_unknown;
      end
      pend_outcome_ff <= pend_outcome_in;
      pend_adv_ff     <= pend_adv_in;
      rsp_pid_ff      <= rsp_pid_in;
      rsp_outcome_ff  <= rsp_outcome_in;
      rsp_adv_ff      <= rsp_adv_in;
      rsp_last_ff     <= rsp_last_in;
   end

   // result channel
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.out_pid    = rsp_pid_ff;
   assign rsp_ch.outcome    = rsp_outcome_ff;
   assign rsp_ch.advance_pc = rsp_adv_ff;
   assign rsp_ch.last       = rsp_last_ff;

endmodule

FILE: hdl/csq_ram.sv
// csq_ram: generic simple dual-port ram, one write and one read port, registered read data
// no dependencies

module csq_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: tb/tb.sv
// tb: self-checking testbench for the counting semaphore bank with per-resource wait queues
// drives random and directed wait/signal requests; checks every result against a model/table
// depends on csq_pkg, csq_if and counting_semaphore_wait_queue

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_RES      = 8;
   localparam int QDEPTH       = 16;
   localparam int CMAX         = 255;
   localparam int LONG_HOLD    = 300;
   localparam int DRAIN_CYCLES = 16;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int NUM_PHASES   = 10;

   typedef struct packed {
      logic [csq_pkg::PID_W-1:0]     pid;
      logic [csq_pkg::OUTCOME_W-1:0] outcome;
      logic                          adv;
      logic                          last;
   } result_type;

   typedef enum logic {ROW_REQ, ROW_CFG} row_kind_type;

   // one directed step: a request repeated reps times (pid counting up), or a register write
   typedef struct packed {
      row_kind_type                  kind;
      logic [csq_pkg::MODE_W-1:0]    mode;
      logic [csq_pkg::RES_W-1:0]     res;
      logic [csq_pkg::PID_W-1:0]     pid;
      logic [8:0]                    reps;
      logic                          typed;
      logic [csq_pkg::OUTCOME_W-1:0] outcome;
      logic                          adv;
      logic [csq_pkg::CFG_W-1:0]     cfg;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   csq_req_if req_ch ();
   csq_rsp_if rsp_ch ();
   csq_csr_if csr_ch ();

   counting_semaphore_wait_queue u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // directed sequence; typed rows carry a single result whose pid is the request pid
   stim_row_type directed_rows [21] = '{
      '{ROW_REQ, csq_pkg::MODE_WAIT,   3'd0, 16'h0000, 9'd1,   1'b1,
        csq_pkg::OUT_BLOCKED, 1'b0, 4'd0},
      '{ROW_REQ, csq_pkg::MODE_SIGNAL, 3'd0, 16'hFFFF, 9'd1,   1'b0,
        csq_pkg::OUT_READY,   1'b0, 4'd0},
      '{ROW_REQ, csq_pkg::MODE_SIGNAL, 3'd7, 16'h1234, 9'd1,   1'b1,
        csq_pkg::OUT_READY,   1'b0, 4'd0},
      '{ROW_REQ, csq_pkg::MODE_WAIT,   3'd7, 16'hABCD, 9'd1,   1'b1,
        csq_pkg::OUT_READY,   1'b1, 4'd0},
      '{ROW_REQ, csq_pkg::MODE_WAIT,   3'd3, 16'h8000, 9'd16,  1'b1,
        csq_pkg::OUT_BLOCKED, 1'b0, 4'd0},
      '{ROW_REQ, csq_pkg::MODE_WAIT,   3'd3, 16'h7FFF, 9'd1,   1'b1,
        csq_pkg::OUT_REJECT,  1'b0, 4'd0},
      '{ROW_REQ, csq_pkg::MODE_SIGNAL, 3'd3, 16'h0100, 9'd16,  1'b0,
        csq_pkg::OUT_READY,   1'b0, 4'd0},
      '{ROW_REQ, csq_pkg::MODE_SIGNAL, 3'd5, 16'h0200, 9'd256, 1'b1,
        csq_pkg::OUT_READY,   1'b0, 4'd0},
      '{ROW_REQ, csq_pkg::MODE_WAIT,   3'd5, 16'h0400, 9'd255, 1'b1,
        csq_pkg::OUT_READY,   1'b1, 4'd0},
      '{ROW_REQ, csq_pkg::MODE_WAIT,   3'd5, 16'h0600, 9'd1,   1'b1,
        csq_pkg::OUT_BLOCKED, 1'b0, 4'd0},
      '{ROW_REQ, csq_pkg::MODE_SIGNAL, 3'd5, 16'h0601, 9'd1,   1'b0,
        csq_pkg::OUT_READY,   1'b0, 4'd0},
      '{ROW_CFG, csq_pkg::MODE_WAIT,   3'd0, 16'h0000, 9'd0,   1'b0,
        csq_pkg::OUT_READY,   1'b0, 4'd1},
      '{ROW_REQ, csq_pkg::MODE_WAIT,   3'd1, 16'h4321, 9'd1,   1'b1,
        csq_pkg::OUT_EXIT,    1'b0, 4'd0},
      '{ROW_REQ, csq_pkg::MODE_SIGNAL, 3'd7, 16'hFFFF, 9'd1,   1'b1,
        csq_pkg::OUT_EXIT,    1'b0, 4'd0},
      '{ROW_REQ, csq_pkg::MODE_WAIT,   3'd0, 16'h2222, 9'd1,   1'b1,
        csq_pkg::OUT_BLOCKED, 1'b0, 4'd0},
      '{ROW_CFG, csq_pkg::MODE_WAIT,   3'd0, 16'h0000, 9'd0,   1'b0,
        csq_pkg::OUT_READY,   1'b0, 4'd0},
      '{ROW_REQ, csq_pkg::MODE_SIGNAL, 3'd0, 16'h3333, 9'd1,   1'b1,
        csq_pkg::OUT_EXIT,    1'b0, 4'd0},
      '{ROW_CFG, csq_pkg::MODE_WAIT,   3'd0, 16'h0000, 9'd0,   1'b0,
        csq_pkg::OUT_READY,   1'b0, 4'd15},
      '{ROW_REQ, csq_pkg::MODE_SIGNAL, 3'd0, 16'h4444, 9'd1,   1'b0,
        csq_pkg::OUT_READY,   1'b0, 4'd0},
      '{ROW_REQ, csq_pkg::MODE_WAIT,   3'd6, 16'h5555, 9'd1,   1'b1,
        csq_pkg::OUT_BLOCKED, 1'b0, 4'd0},
      '{ROW_REQ, csq_pkg::MODE_SIGNAL, 3'd6, 16'h6666, 9'd1,   1'b0,
        csq_pkg::OUT_READY,   1'b0, 4'd0}
   };

   // random phases: register setting and share of waits in each
   logic [csq_pkg::CFG_W-1:0] phase_cfg [NUM_PHASES] = '{
      4'd8, 4'd3, 4'd8, 4'd1, 4'd15, 4'd5, 4'd0, 4'd9, 4'd2, 4'd8
   };
   int phase_wait_pct [NUM_PHASES] = '{50, 85, 45, 90, 30, 60, 50, 80, 55, 15};

   // model state of the semaphore bank
   logic [7:0]                sem_count [NUM_RES];
   logic [csq_pkg::PID_W-1:0] waiters   [NUM_RES][QDEPTH];
   logic [3:0]                q_head    [NUM_RES];
   logic [3:0]                q_tail    [NUM_RES];
   logic [4:0]                q_fill    [NUM_RES];
   logic [csq_pkg::CFG_W-1:0] res_limit;

   result_type awaited_results [$];
   result_type want, got, first_rel, second_rel;
   int         rel_count;

   // what the current request transaction is to be checked against
   logic                          offer_typed;
   logic [csq_pkg::OUTCOME_W-1:0] offer_outcome;
   logic                          offer_adv;

   bit no_idle;
   int long_hold_asked;
   int long_hold_done;
   int fail_count;
   int cycle_count;

   // clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic void note_failure(input string what);
      fail_count++;
      if (fail_count <= 10) begin
         $display("cycle %0d: %s", cycle_count, what);
      end
   endfunction

   // applies one request to the model state and returns the number of results it releases
   function automatic int semaphore_decide(input logic [csq_pkg::MODE_W-1:0] mode,
                                           input logic [csq_pkg::RES_W-1:0] res,
                                           input logic [csq_pkg::PID_W-1:0] pid,
                                           output result_type first,
                                           output result_type second);
      int lim;
      lim = res_limit;
      if (lim > NUM_RES) lim = NUM_RES;
      second = '0;
      if (res >= lim) begin
         first = result_type'{pid, csq_pkg::OUT_EXIT, 1'b0, 1'b1};
         return 1;
      end
      if (mode == csq_pkg::MODE_WAIT) begin
         if (sem_count[res] != 8'd0) begin
            sem_count[res] = sem_count[res] - 8'd1;
            first = result_type'{pid, csq_pkg::OUT_READY, 1'b1, 1'b1};
            return 1;
         end
         if (q_fill[res] >= QDEPTH) begin
            first = result_type'{pid, csq_pkg::OUT_REJECT, 1'b0, 1'b1};
            return 1;
         end
         // 4-bit pointers wrap at the queue depth
         waiters[res][q_tail[res]] = pid;
         q_tail[res] = q_tail[res] + 4'd1;
         q_fill[res] = q_fill[res] + 5'd1;
         first = result_type'{pid, csq_pkg::OUT_BLOCKED, 1'b0, 1'b1};
         return 1;
      end
      // signal: hand the unit straight to the oldest waiter if there is one
      if (q_fill[res] != 5'd0) begin
         first = result_type'{waiters[res][q_head[res]], csq_pkg::OUT_READY, 1'b1, 1'b0};
         q_head[res] = q_head[res] + 4'd1;
         q_fill[res] = q_fill[res] - 5'd1;
         second = result_type'{pid, csq_pkg::OUT_READY, 1'b0, 1'b1};
         return 2;
      end
      if (sem_count[res] < CMAX) sem_count[res] = sem_count[res] + 8'd1;
      first = result_type'{pid, csq_pkg::OUT_READY, 1'b0, 1'b1};
      return 1;
   endfunction

   // offer one request transaction after a random gap, return at the falling edge after it
   task automatic send_req(input logic [csq_pkg::MODE_W-1:0] mode,
                           input logic [csq_pkg::RES_W-1:0] res,
                           input logic [csq_pkg::PID_W-1:0] pid, input logic typed,
                           input logic [csq_pkg::OUTCOME_W-1:0] outcome, input logic adv);
      int gap;
      gap = no_idle ? 0 : pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      offer_typed   = typed;
      offer_outcome = outcome;
      offer_adv     = adv;
      req_ch.valid    <= 1'b1;
      req_ch.mode     <= mode;
      req_ch.resource <= res;
      req_ch.pid      <= pid;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
   endtask

   // stop offering and wait until every awaited result has come back
   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      @(negedge clock);
      while (awaited_results.size() != 0) @(negedge clock);
   endtask

   task automatic write_cfg(input logic [csq_pkg::CFG_W-1:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.data  <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // result check, register tracking and prediction, in that order at each edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = result_type'{rsp_ch.out_pid, rsp_ch.outcome, rsp_ch.advance_pc, rsp_ch.last};
            if (awaited_results.size() == 0) begin
               note_failure($sformatf("unexpected result pid %h outcome %0d adv %0b last %0b",
                                      got.pid, got.outcome, got.adv, got.last));
            end else begin
               want = awaited_results.pop_front();
               if (got.pid !== want.pid || got.outcome !== want.outcome ||
                   got.adv !== want.adv || got.last !== want.last) begin
                  note_failure($sformatf(
                     "expected pid %h outcome %0d adv %0b last %0b, got %h %0d %0b %0b",
                     want.pid, want.outcome, want.adv, want.last,
                     got.pid, got.outcome, got.adv, got.last));
               end
            end
         end
         if (csr_ch.valid && csr_ch.ready) res_limit = csr_ch.data;
         if (req_ch.valid && req_ch.ready) begin
            rel_count = semaphore_decide(req_ch.mode, req_ch.resource, req_ch.pid,
                                         first_rel, second_rel);
            if (offer_typed) begin
               awaited_results.push_back(
                  result_type'{req_ch.pid, offer_outcome, offer_adv, 1'b1});
            end else begin
               awaited_results.push_back(first_rel);
               if (rel_count == 2) awaited_results.push_back(second_rel);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // result ready: random stalls, and a long hold-off whenever one is asked for
   initial begin
      int hold_left;
      hold_left = 0;
      long_hold_done = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (long_hold_done != long_hold_asked) begin
            long_hold_done++;
            hold_left = LONG_HOLD - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            hold_left = no_idle ? 0 : pick_gap();
            rsp_ch.ready <= (hold_left == 0);
            if (hold_left > 0) hold_left--;
         end
      end
   end

   // stimulus
   initial begin
      int k, ph, lim, spread, wait_pct, n_items;
      stim_row_type row;
      logic [csq_pkg::MODE_W-1:0] m;
      logic [csq_pkg::RES_W-1:0]  rs;
      logic [csq_pkg::PID_W-1:0]  p;

      req_ch.valid    = 1'b0;
      req_ch.mode     = csq_pkg::MODE_WAIT;
      req_ch.resource = '0;
      req_ch.pid      = '0;
      csr_ch.valid    = 1'b0;
      csr_ch.data     = '0;
      offer_typed     = 1'b0;
      offer_outcome   = csq_pkg::OUT_READY;
      offer_adv       = 1'b0;
      no_idle         = 1'b0;
      long_hold_asked = 0;
      fail_count      = 0;
      cycle_count     = 0;
      res_limit       = csq_pkg::RES_IN_USE_RESET;
      for (k = 0; k < NUM_RES; k++) begin
         sem_count[k] = '0;
         q_head[k]    = '0;
         q_tail[k]    = '0;
         q_fill[k]    = '0;
      end

      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // directed part
      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.kind == ROW_CFG) begin
            wait_idle();
            write_cfg(row.cfg);
         end else begin
            for (k = 0; k < row.reps; k++) begin
               p = row.pid + 16'(k);
               send_req(row.mode, row.res, p, row.typed, row.outcome, row.adv);
            end
         end
      end

      // random part, one register setting per phase
      for (ph = 0; ph < NUM_PHASES; ph++) begin
         wait_idle();
         write_cfg(phase_cfg[ph]);
         no_idle  = (ph == 2);
         wait_pct = phase_wait_pct[ph];
         lim      = (phase_cfg[ph] > NUM_RES) ? NUM_RES : phase_cfg[ph];
         // a narrow spread piles waiters onto few resources so queues fill up
         if (lim == 0) spread = 1;
         else if ($urandom_range(0, 1) == 0) spread = lim;
         else spread = $urandom_range(1, lim);
         n_items = (lim == 0) ? 20 : 50;
         for (k = 0; k < n_items; k++) begin
            if (ph == 3 && k == 20) long_hold_asked++;
            if (ph == 5 && k == 30) wait_idle();
            m = ($urandom_range(0, 99) < wait_pct) ? csq_pkg::MODE_WAIT : csq_pkg::MODE_SIGNAL;
            if (lim == 0 || $urandom_range(0, 9) == 0) rs = 3'($urandom_range(0, NUM_RES - 1));
            else rs = 3'($urandom_range(0, spread - 1));
            case ($urandom_range(0, 7))
               0: p = '0;
               1: p = '1;
               default: p = 16'($urandom);
            endcase
            send_req(m, rs, p, 1'b0, csq_pkg::OUT_READY, 1'b0);
         end
      end

      // drain and report
      no_idle = 1'b0;
      wait_idle();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

FILE: sim.f
hdl/csq_pkg.sv
hdl/csq_if.sv
hdl/csq_ram.sv
hdl/counting_semaphore_wait_queue.sv
tb/tb.sv
